FILE: rtl/core/brb_pkg.sv
// Shared types and constants for the remap box planner.
`timescale 1ns / 1ps

package brb_pkg;

    // Fixed field widths.
    localparam int unsigned RANK_W = 18;
    localparam int unsigned CNT_W  = 7;
    localparam int unsigned OUT_W  = 9;
    localparam int unsigned IDX_W  = 3;
    localparam int unsigned SLOTS  = 6;
    localparam int unsigned SEL_W  = 3;

    // Configuration register indexes.
    typedef enum logic [IDX_W-1:0] {
        CFG_SRC_X = 3'd0,
        CFG_SRC_Y = 3'd1,
        CFG_SRC_Z = 3'd2,
        CFG_DST_X = 3'd3,
        CFG_DST_Y = 3'd4,
        CFG_DST_Z = 3'd5,
        CFG_DEST  = 3'd6
    } t_cfg_reg;

    // Result kinds and axes.
    localparam logic KIND_NODE = 1'b0;
    localparam logic KIND_CELL = 1'b1;
    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    // Control word that leaves the span unit with each request.
    typedef struct packed {
        logic       valid;
        logic       ok;
        logic [2:0] lastc;
    } t_span_ctl;

endpackage

FILE: rtl/core/brb_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
`timescale 1ns / 1ps

module brb_div
    import brb_pkg::*;
#(
    parameter int unsigned NW = 18,
    parameter int unsigned SW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic [NW-1:0] i_num,
    input  logic [NW-1:0] i_den,
    input  logic [SW-1:0] i_side,
    output logic [NW-1:0] o_quo,
    output logic [NW-1:0] o_rem,
    output logic [SW-1:0] o_side
);

    logic [NW-1:0] r_num  [NW];
    logic [NW-1:0] r_den  [NW];
    logic [NW-1:0] r_quo  [NW];
    logic [NW-1:0] r_rem  [NW];
    logic [SW-1:0] r_side [NW];

    for (genvar i = 0; i < NW; i++) begin : g_stage
        logic [NW-1:0] p_num, p_den, p_quo, p_rem;
        logic [SW-1:0] p_side;
        logic [NW:0]   trial;
        logic          fits;
        logic [NW:0]   diff;

        // Operands come from the previous stage, or from the ports at the head.
        if (i == 0) begin : g_head
            assign p_num  = i_num;
            assign p_den  = i_den;
            assign p_quo  = '0;
            assign p_rem  = '0;
            assign p_side = i_side;
        end else begin : g_body
            assign p_num  = r_num[i-1];
            assign p_den  = r_den[i-1];
            assign p_quo  = r_quo[i-1];
            assign p_rem  = r_rem[i-1];
            assign p_side = r_side[i-1];
        end

        // Bring down the next numerator bit and try the subtraction.
        always_comb begin
            trial = {p_rem, p_num[NW-1]};
            diff  = trial - {1'b0, p_den};
            fits  = (trial >= {1'b0, p_den});
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_side[i] <= '0;
            end else if (i_en) begin
                r_side[i] <= p_side;
                r_num[i]  <= {p_num[NW-2:0], 1'b0};
                r_den[i]  <= p_den;
                r_quo[i]  <= {p_quo[NW-2:0], fits};
                r_rem[i]  <= fits ? diff[NW-1:0] : trial[NW-1:0];
            end
        end
    end

    assign o_quo  = r_quo[NW-1];
    assign o_rem  = r_rem[NW-1];
    assign o_side = r_side[NW-1];

endmodule

FILE: rtl/core/brb_span.sv
// Per-axis cell spans of one rank: coordinate split, chunk size and interval ends.
`timescale 1ns / 1ps

module brb_span
    import brb_pkg::*;
#(
    parameter int unsigned CELLS_X = 256,
    parameter int unsigned CELLS_Y = 256,
    parameter int unsigned CELLS_Z = 256,
    parameter int unsigned CW      = 7,
    parameter int unsigned XW      = 9,
    parameter int unsigned NW      = 18,
    parameter int unsigned BW      = 17
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  logic [RANK_W-1:0]      i_rank,
    input  logic [2:0][CW-1:0]     i_cnt,
    output t_span_ctl              o_ctl,
    output logic [2:0][BW-1:0]     o_beg,
    output logic [2:0][BW-1:0]     o_end
);

    // Input stage.
    logic                  r_v0;
    logic [RANK_W-1:0]     r_rank0;
    logic [2:0][CW-1:0]    r_cnt0;

    // Plane size stage.
    logic                  r_v1;
    logic [RANK_W-1:0]     r_rank1;
    logic [2:0][CW-1:0]    r_cnt1;
    logic [2*CW-1:0]       r_plane1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
        end else if (i_en) begin
            r_v0     <= i_valid;
            r_rank0  <= i_rank;
            r_cnt0   <= i_cnt;
            r_v1     <= r_v0;
            r_rank1  <= r_rank0;
            r_cnt1   <= r_cnt0;
            r_plane1 <= r_cnt0[1] * r_cnt0[2];
        end
    end

    // First division: rank over the y-z plane gives the x coordinate.
    logic [NW-1:0]       d1_quo, d1_rem;
    logic [3*CW:0]       d1_side;
    logic [2:0][CW-1:0]  d1_cnt;
    logic                d1_v;
    logic                d1_in_range;

    brb_div #(.NW(NW), .SW(3*CW+1)) u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_num   (NW'(r_rank1)),
        .i_den   (NW'(r_plane1)),
        .i_side  ({r_cnt1, r_v1}),
        .o_quo   (d1_quo),
        .o_rem   (d1_rem),
        .o_side  (d1_side)
    );

    // The rank is in range exactly when the x coordinate is below the x count.
    always_comb begin
        d1_cnt      = d1_side[3*CW:1];
        d1_v        = d1_side[0];
        d1_in_range = (d1_quo < NW'(d1_cnt[0]));
    end

    // Second division: the remainder over the z count gives y and z.
    logic [NW-1:0] d2_quo, d2_rem;
    logic [CW+1:0] d2_side;

    brb_div #(.NW(NW), .SW(CW+2)) u_div_yz (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_num   (d1_rem),
        .i_den   (NW'(d1_cnt[2])),
        .i_side  ({d1_quo[CW-1:0], d1_in_range, d1_v}),
        .o_quo   (d2_quo),
        .o_rem   (d2_rem),
        .o_side  (d2_side)
    );

    localparam logic [2:0][BW-1:0] GRID_END = {BW'(CELLS_Z), BW'(CELLS_Y), BW'(CELLS_X)};

    logic [2:0][CW-1:0] coord;
    logic [2:0][XW-1:0] chunk;
    logic [2:0][CW-1:0] cnt_out;
    logic [NW-1:0]      ch_quo [3];
    logic [2:0]         lastc;
    logic [2:0][BW-1:0] beg, fin;

    always_comb begin
        coord[0] = d2_side[CW+1:2];
        coord[1] = d2_quo[CW-1:0];
        coord[2] = d2_rem[CW-1:0];
    end

    // Chunk size per axis, ceiling of cells over ranks, alongside the second division.
    for (genvar a = 0; a < 3; a++) begin : g_axis
        localparam int unsigned CA = (a == 0) ? CELLS_X : ((a == 1) ? CELLS_Y : CELLS_Z);

        brb_div #(.NW(NW), .SW(CW)) u_div_chunk (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (i_en),
            .i_num   (NW'(CA) + NW'(d1_cnt[a]) - NW'(1)),
            .i_den   (NW'(d1_cnt[a])),
            .i_side  (d1_cnt[a]),
            .o_quo   (ch_quo[a]),
            .o_rem   (),
            .o_side  (cnt_out[a])
        );
    end

    // The last rank of an axis always ends at the grid edge.
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            chunk[a] = ch_quo[a][XW-1:0];
            lastc[a] = (coord[a] == (cnt_out[a] - CW'(1)));
            beg[a]   = BW'(coord[a]) * BW'(chunk[a]);
            fin[a]   = lastc[a] ? GRID_END[a] : (beg[a] + BW'(chunk[a]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_ctl <= '0;
        end else if (i_en) begin
            o_ctl.valid <= d2_side[0];
            o_ctl.ok    <= d2_side[1];
            o_ctl.lastc <= lastc;
            o_beg       <= beg;
            o_end       <= fin;
        end
    end

endmodule

FILE: rtl/core/brb_emit.sv
// Box intersection and the result queue that sends one result per cycle.
`timescale 1ns / 1ps

module brb_emit
    import brb_pkg::*;
#(
    parameter int unsigned BW = 17
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_span_ctl          i_src_ctl,
    input  logic [2:0][BW-1:0] i_src_beg,
    input  logic [2:0][BW-1:0] i_src_end,
    input  t_span_ctl          i_dst_ctl,
    input  logic [2:0][BW-1:0] i_dst_beg,
    input  logic [2:0][BW-1:0] i_dst_end,
    output logic               o_load_ok,
    output logic               o_strobe,
    output logic               o_copy_kind,
    output logic [1:0]         o_axis,
    output logic [OUT_W-1:0]   o_global_begin,
    output logic [OUT_W-1:0]   o_global_end,
    output logic [OUT_W-1:0]   o_source_local_begin,
    output logic [OUT_W-1:0]   o_dest_local_begin,
    output logic               o_last
);

    // Overlap of the two boxes, node and cell, per axis.
    logic [2:0][BW-1:0]    gb, ge_node, ge_cell, s_own_end, d_node_end, sl, dl;
    logic [2:0]            node_ne, cell_ne;
    logic                  node_ok, cell_ok;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            s_own_end[a]  = i_src_end[a] + BW'(i_src_ctl.lastc[a]);
            d_node_end[a] = i_dst_end[a] + BW'(1);
            gb[a]      = (i_src_beg[a] > i_dst_beg[a]) ? i_src_beg[a] : i_dst_beg[a];
            ge_node[a] = (s_own_end[a] < d_node_end[a]) ? s_own_end[a] : d_node_end[a];
            ge_cell[a] = (i_src_end[a] < i_dst_end[a]) ? i_src_end[a] : i_dst_end[a];
            node_ne[a] = (gb[a] < ge_node[a]);
            cell_ne[a] = (gb[a] < ge_cell[a]);
            sl[a]      = gb[a] - i_src_beg[a];
            dl[a]      = gb[a] - i_dst_beg[a];
        end
        node_ok = i_src_ctl.ok && i_dst_ctl.ok && (&node_ne);
        cell_ok = i_src_ctl.ok && i_dst_ctl.ok && (&cell_ne);
    end

    // Result slots: node x, y, z, then cell x, y, z, with a pending mask.
    logic [SLOTS-1:0]  r_mask, n_mask, mask_after;
    logic [OUT_W-1:0]  r_gb [SLOTS];
    logic [OUT_W-1:0]  r_ge [SLOTS];
    logic [OUT_W-1:0]  r_sl [SLOTS];
    logic [OUT_W-1:0]  r_dl [SLOTS];
    logic [SEL_W-1:0]  sel;
    logic              any;
    logic              load;

    // Lowest pending slot goes out next.
    always_comb begin
        sel = '0;
        any = 1'b0;
        for (int s = SLOTS - 1; s >= 0; s--) begin
            if (r_mask[s]) begin
                sel = SEL_W'(s);
                any = 1'b1;
            end
        end
        mask_after = r_mask & ~(SLOTS'(any) << sel);
        o_load_ok  = ((r_mask & (r_mask - SLOTS'(1))) == '0);
        load       = i_src_ctl.valid && o_load_ok;
        n_mask     = load ? {{3{cell_ok}}, {3{node_ok}}} : mask_after;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
        end else begin
            r_mask <= n_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            for (int a = 0; a < 3; a++) begin
                r_gb[a]   <= gb[a][OUT_W-1:0];
                r_ge[a]   <= ge_node[a][OUT_W-1:0];
                r_sl[a]   <= sl[a][OUT_W-1:0];
                r_dl[a]   <= dl[a][OUT_W-1:0];
                r_gb[a+3] <= gb[a][OUT_W-1:0];
                r_ge[a+3] <= ge_cell[a][OUT_W-1:0];
                r_sl[a+3] <= sl[a][OUT_W-1:0];
                r_dl[a+3] <= dl[a][OUT_W-1:0];
            end
        end
    end

    // Kind and axis of the chosen slot.
    logic       n_kind;
    logic [1:0] n_axis;

    always_comb begin
        case (sel)
            3'd0:    begin n_kind = KIND_NODE; n_axis = AXIS_X; end
            3'd1:    begin n_kind = KIND_NODE; n_axis = AXIS_Y; end
            3'd2:    begin n_kind = KIND_NODE; n_axis = AXIS_Z; end
            3'd3:    begin n_kind = KIND_CELL; n_axis = AXIS_X; end
            3'd4:    begin n_kind = KIND_CELL; n_axis = AXIS_Y; end
            3'd5:    begin n_kind = KIND_CELL; n_axis = AXIS_Z; end
            default: begin n_kind = KIND_NODE; n_axis = AXIS_X; end
        endcase
    end

    // Output register.
    logic r_out_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
            o_last  <= 1'b0;
        end else begin
            r_out_v <= any;
            o_last  <= any && (mask_after == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        o_copy_kind          <= n_kind;
        o_axis               <= n_axis;
        o_global_begin       <= r_gb[sel];
        o_global_end         <= r_ge[sel];
        o_source_local_begin <= r_sl[sel];
        o_dest_local_begin   <= r_dl[sel];
    end

    assign o_strobe = r_out_v;

endmodule

FILE: rtl/core/block_decomposition_remap_boxes.sv
// Top level of the remap box planner for a block-decomposed grid.
//
//   channel   direction  handshake                      contents
//   request   in         start high, busy low           source_rank
//   config    in         i_cfg_valid and o_cfg_ready     register index, data
//   result    out        o_strobe for one cycle          kind, axis, interval, local begins, last
//
// A request enters the span pipeline in any cycle that busy is low; its results then
// come out one per cycle, zero, three or six in all.
// The depth is set by two chained one-bit-per-stage dividers of NW stages each.
// The pipeline holds while the result queue has two or more results left, so the queue
// takes a new request while the last result of the one before goes out.
// Reset is synchronous and clears all valid bits and the registers to one rank per axis.
// The result side cannot stall; results are never held.
`timescale 1ns / 1ps

module block_decomposition_remap_boxes
    import brb_pkg::*;
#(
    parameter int unsigned CELLS_X            = 256,
    parameter int unsigned CELLS_Y            = 256,
    parameter int unsigned CELLS_Z            = 256,
    parameter int unsigned MAX_RANKS_PER_AXIS = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [RANK_W-1:0] i_source_rank,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [IDX_W-1:0]  i_cfg_index,
    input  logic [RANK_W-1:0] i_cfg_data,
    output logic              o_strobe,
    output logic              o_copy_kind,
    output logic [1:0]        o_axis,
    output logic [OUT_W-1:0]  o_global_begin,
    output logic [OUT_W-1:0]  o_global_end,
    output logic [OUT_W-1:0]  o_source_local_begin,
    output logic [OUT_W-1:0]  o_dest_local_begin,
    output logic              o_last
);

    localparam int unsigned MAXC = (CELLS_X > CELLS_Y)
        ? ((CELLS_X > CELLS_Z) ? CELLS_X : CELLS_Z)
        : ((CELLS_Y > CELLS_Z) ? CELLS_Y : CELLS_Z);
    localparam int unsigned CW  = $clog2(MAX_RANKS_PER_AXIS + 1);
    localparam int unsigned XW  = $clog2(MAXC + MAX_RANKS_PER_AXIS);
    localparam int unsigned NW0 = (RANK_W > 2 * CW) ? RANK_W : 2 * CW;
    localparam int unsigned NW  = (NW0 > XW) ? NW0 : XW;
    localparam int unsigned BW  = CW + XW + 1;

    // Rank counts are kept already clamped to the range one to the maximum.
    logic [2:0][CW-1:0]   r_src_cnt, r_dst_cnt;
    logic [RANK_W-1:0]    r_dest_rank;
    logic [CW-1:0]        n_cnt;
    logic [CNT_W-1:0]     wr_cnt;

    always_comb begin
        wr_cnt = i_cfg_data[CNT_W-1:0];
        if (wr_cnt == '0) begin
            n_cnt = CW'(1);
        end else if (32'(wr_cnt) > MAX_RANKS_PER_AXIS) begin
            n_cnt = CW'(MAX_RANKS_PER_AXIS);
        end else begin
            n_cnt = CW'(wr_cnt);
        end
    end

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_cnt   <= {3{CW'(1)}};
            r_dst_cnt   <= {3{CW'(1)}};
            r_dest_rank <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SRC_X: r_src_cnt[0] <= n_cnt;
                CFG_SRC_Y: r_src_cnt[1] <= n_cnt;
                CFG_SRC_Z: r_src_cnt[2] <= n_cnt;
                CFG_DST_X: r_dst_cnt[0] <= n_cnt;
                CFG_DST_Y: r_dst_cnt[1] <= n_cnt;
                CFG_DST_Z: r_dst_cnt[2] <= n_cnt;
                CFG_DEST:  r_dest_rank  <= i_cfg_data;
                default:   ;
            endcase
        end
    end

    // Pipeline advance: hold while a finished request waits for queue space.
    t_span_ctl          src_ctl, dst_ctl;
    logic [2:0][BW-1:0] src_beg, src_end, dst_beg, dst_end;
    logic               load_ok;
    logic               en;

    assign en   = !src_ctl.valid || load_ok;
    assign busy = !en;

    brb_span #(
        .CELLS_X (CELLS_X), .CELLS_Y (CELLS_Y), .CELLS_Z (CELLS_Z),
        .CW (CW), .XW (XW), .NW (NW), .BW (BW)
    ) u_span_src (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (start),
        .i_rank  (i_source_rank),
        .i_cnt   (r_src_cnt),
        .o_ctl   (src_ctl),
        .o_beg   (src_beg),
        .o_end   (src_end)
    );

    // The destination box runs in lockstep so both arrive together.
    brb_span #(
        .CELLS_X (CELLS_X), .CELLS_Y (CELLS_Y), .CELLS_Z (CELLS_Z),
        .CW (CW), .XW (XW), .NW (NW), .BW (BW)
    ) u_span_dst (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (start),
        .i_rank  (r_dest_rank),
        .i_cnt   (r_dst_cnt),
        .o_ctl   (dst_ctl),
        .o_beg   (dst_beg),
        .o_end   (dst_end)
    );

    brb_emit #(.BW (BW)) u_emit (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_src_ctl            (src_ctl),
        .i_src_beg            (src_beg),
        .i_src_end            (src_end),
        .i_dst_ctl            (dst_ctl),
        .i_dst_beg            (dst_beg),
        .i_dst_end            (dst_end),
        .o_load_ok            (load_ok),
        .o_strobe             (o_strobe),
        .o_copy_kind          (o_copy_kind),
        .o_axis               (o_axis),
        .o_global_begin       (o_global_begin),
        .o_global_end         (o_global_end),
        .o_source_local_begin (o_source_local_begin),
        .o_dest_local_begin   (o_dest_local_begin),
        .o_last               (o_last)
    );

endmodule

FILE: rtl/core/brb_chk.sv
// Port-level checks on the result stream of the remap box planner.
`timescale 1ns / 1ps

module brb_chk
    import brb_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_strobe,
    input logic       o_copy_kind,
    input logic [1:0] o_axis,
    input logic       o_last
);

    // The last flag only marks a real result.
    a_last_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last |-> o_strobe)
        else $error("last flag without a result");

    // Only a z result can close a request.
    a_last_on_z: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_last) |-> (o_axis == AXIS_Z))
        else $error("request closed on an axis other than z");

    // Results of one request follow without gaps.
    a_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_last) |=> o_strobe)
        else $error("gap inside the results of a request");

    // Axes step x, y, z inside one overlap.
    a_axis_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_last && o_axis != AXIS_Z) |=>
            (o_copy_kind == $past(o_copy_kind) && o_axis == $past(o_axis) + 2'd1))
        else $error("axis order broken");

    // A node overlap that is not last is followed by the cell overlap.
    a_node_then_cell: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_last && o_axis == AXIS_Z) |=>
            (o_copy_kind == KIND_CELL && o_axis == AXIS_X))
        else $error("cell overlap does not follow node overlap");

endmodule

bind block_decomposition_remap_boxes brb_chk u_brb_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_strobe    (o_strobe),
    .o_copy_kind (o_copy_kind),
    .o_axis      (o_axis),
    .o_last      (o_last)
);

FILE: tb/block_decomposition_remap_boxes_tb.sv
// Self-checking testbench for the remap box planner: directed and random requests.
`timescale 1ns / 1ps

module block_decomposition_remap_boxes_tb;
    import brb_pkg::*;

    localparam int CELLS      = 256;
    localparam int MAX_RANKS  = 64;
    localparam int DRAIN      = 60;
    localparam int IDLE_LIMIT = 4000;
    localparam logic [IDX_W-1:0] CFG_UNUSED = 3'd7;

    typedef longint trio_t [3];

    // One per-axis overlap as the block should emit it.
    typedef struct packed {
        bit             kind;
        bit [1:0]       axis;
        bit [OUT_W-1:0] gbeg;
        bit [OUT_W-1:0] gend;
        bit [OUT_W-1:0] sbeg;
        bit [OUT_W-1:0] dbeg;
        bit             last;
    } box_t;

    // Keeps a copy of the registers, works out the overlaps of each request and checks them.
    class overlap_tracker;
        longint regs[7];
        box_t   expected_boxes[$];
        int     errors;

        function new();
            regs = '{1, 1, 1, 1, 1, 1, 0};
            errors = 0;
        endfunction

        function void set_reg(logic [IDX_W-1:0] idx, logic [RANK_W-1:0] value);
            if (idx == CFG_DEST)
                regs[6] = value;
            else if (idx <= CFG_DST_Z)
                regs[idx] = value & 7'h7F;
        endfunction

        function longint clamp_count(longint v);
            if (v == 0) return 1;
            if (v > MAX_RANKS) return MAX_RANKS;
            return v;
        endfunction

        // Cell spans and node ends of one rank; returns 0 when the rank is out of range.
        function bit rank_spans(trio_t cnt, longint rank, output trio_t cb, output trio_t ce,
                                output trio_t ne, output trio_t oe);
            longint r, per, n;
            longint coord[3];
            bit lastc;
            if (rank >= cnt[0] * cnt[1] * cnt[2]) return 0;
            coord[0] = rank / (cnt[1] * cnt[2]);
            r = rank - coord[0] * cnt[1] * cnt[2];
            coord[1] = r / cnt[2];
            coord[2] = r - coord[1] * cnt[2];
            for (int a = 0; a < 3; a++) begin
                per = (CELLS + cnt[a] - 1) / cnt[a];
                lastc = (coord[a] == cnt[a] - 1);
                n = lastc ? CELLS - per * (cnt[a] - 1) : per;
                cb[a] = coord[a] * per;
                ce[a] = cb[a] + n;
                ne[a] = ce[a] + 1;
                oe[a] = lastc ? ne[a] : ne[a] - 1;
            end
            return 1;
        endfunction

        // Intersects two boxes and queues three results when every axis overlaps.
        function void add_overlap(bit kind, trio_t sb, trio_t se, trio_t db, trio_t de);
            longint gb[3], ge[3];
            box_t box;
            for (int a = 0; a < 3; a++) begin
                gb[a] = sb[a] > db[a] ? sb[a] : db[a];
                ge[a] = se[a] < de[a] ? se[a] : de[a];
                if (gb[a] >= ge[a]) return;
            end
            for (int a = 0; a < 3; a++) begin
                box.kind = kind;
                box.axis = 2'(a);
                box.gbeg = OUT_W'(gb[a]);
                box.gend = OUT_W'(ge[a]);
                box.sbeg = OUT_W'(gb[a] - sb[a]);
                box.dbeg = OUT_W'(gb[a] - db[a]);
                box.last = 0;
                expected_boxes = {expected_boxes, box};
            end
        endfunction

        function void note_rank(logic [RANK_W-1:0] rank);
            trio_t sc, dc, scb, sce, sne, soe, dcb, dce, dne, doe;
            int before_n;
            for (int a = 0; a < 3; a++) begin
                sc[a] = clamp_count(regs[a]);
                dc[a] = clamp_count(regs[a + 3]);
            end
            if (!rank_spans(dc, regs[6], dcb, dce, dne, doe)) return;
            if (!rank_spans(sc, rank, scb, sce, sne, soe)) return;
            before_n = expected_boxes.size();
            add_overlap(KIND_NODE, scb, soe, dcb, dne);
            add_overlap(KIND_CELL, scb, sce, dcb, dce);
            if (expected_boxes.size() > before_n)
                expected_boxes[expected_boxes.size() - 1].last = 1;
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        task check_result(box_t got);
            box_t want;
            if (expected_boxes.size() == 0) begin
                report($sformatf("unexpected result kind=%0d axis=%0d", got.kind, got.axis));
                return;
            end
            want = expected_boxes.pop_front();
            if (got != want)
                report($sformatf("got k%0d a%0d [%0d,%0d) s%0d d%0d l%0d, want k%0d a%0d [%0d,%0d) s%0d d%0d l%0d",
                    got.kind, got.axis, got.gbeg, got.gend, got.sbeg, got.dbeg, got.last,
                    want.kind, want.axis, want.gbeg, want.gend, want.sbeg, want.dbeg, want.last));
        endtask
    endclass

    logic              i_clk = 0;
    logic              i_rst_n = 0;
    logic              start = 0;
    logic              busy;
    logic [RANK_W-1:0] i_source_rank = '0;
    logic              i_cfg_valid = 0;
    logic              o_cfg_ready;
    logic [IDX_W-1:0]  i_cfg_index = '0;
    logic [RANK_W-1:0] i_cfg_data = '0;
    logic              o_strobe;
    logic              o_copy_kind;
    logic [1:0]        o_axis;
    logic [OUT_W-1:0]  o_global_begin;
    logic [OUT_W-1:0]  o_global_end;
    logic [OUT_W-1:0]  o_source_local_begin;
    logic [OUT_W-1:0]  o_dest_local_begin;
    logic              o_last;

    overlap_tracker tracker = new();
    int idle_cycles = 0;
    bit no_gaps = 0;

    block_decomposition_remap_boxes u_top (.*);

    always #2 i_clk = ~i_clk;

    // Results are taken at the edge that ends their strobe cycle.
    always @(posedge i_clk) begin
        box_t got;
        if (i_rst_n && o_strobe) begin
            got = '{o_copy_kind, o_axis, o_global_begin, o_global_end,
                    o_source_local_begin, o_dest_local_begin, o_last};
            tracker.check_result(got);
        end
    end

    // Ends the run when nothing moves on any channel for too long.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_strobe || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT) begin
            $display("[block_decomposition_remap_boxes] ERROR");
            $finish;
        end
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (no_gaps || roll < 55) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic write_reg(logic [IDX_W-1:0] idx, int unsigned value);
        @(negedge i_clk);
        i_cfg_valid = 1;
        i_cfg_index = idx;
        i_cfg_data = RANK_W'(value);
        do @(posedge i_clk); while (!o_cfg_ready);
        tracker.set_reg(idx, RANK_W'(value));
        @(negedge i_clk);
        i_cfg_valid = 0;
    endtask

    // Holds the request until the block takes it, then sometimes idles for a random gap.
    task automatic send_rank(int unsigned rank);
        int gap;
        @(negedge i_clk);
        start = 1;
        i_source_rank = RANK_W'(rank);
        do @(posedge i_clk); while (busy);
        tracker.note_rank(RANK_W'(rank));
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            start = 0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    // Waits for every expected result, then lets any request without results leave the pipe.
    task automatic wait_idle();
        @(negedge i_clk);
        start = 0;
        while (tracker.expected_boxes.size() > 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    task automatic set_grids(int unsigned sx, int unsigned sy, int unsigned sz,
                             int unsigned dx, int unsigned dy, int unsigned dz,
                             int unsigned dest);
        write_reg(CFG_SRC_X, sx);
        write_reg(CFG_SRC_Y, sy);
        write_reg(CFG_SRC_Z, sz);
        write_reg(CFG_DST_X, dx);
        write_reg(CFG_DST_Y, dy);
        write_reg(CFG_DST_Z, dz);
        write_reg(CFG_DEST, dest);
    endtask

    function automatic int unsigned rand_count();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 5) return 0;
        if (roll < 10) return $urandom_range(0, 2 ** RANK_W - 1);
        if (roll < 20) return $urandom_range(56, 127);
        return $urandom_range(1, 8);
    endfunction

    function automatic longint rank_total(int base);
        longint t;
        t = 1;
        for (int a = 0; a < 3; a++)
            t *= tracker.clamp_count(tracker.regs[base + a]);
        return t;
    endfunction

    initial begin
        longint total;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // One rank on each side: the whole grid overlaps; out of range ranks give nothing.
        send_rank(0);
        send_rank(1);
        send_rank(2 ** RANK_W - 1);
        wait_idle();

        // Largest source grid against one destination rank, corners and far end.
        set_grids(64, 64, 64, 1, 1, 1, 0);
        send_rank(0);
        send_rank(63);
        send_rank(64 * 64 * 64 - 1);
        send_rank(2 ** RANK_W - 1);
        wait_idle();

        // Uneven splits, reversed last intervals and a destination rank out of range.
        set_grids(60, 3, 7, 63, 2, 5, 63 * 2 * 5 - 1);
        send_rank(0);
        send_rank(59 * 21 + 20);
        send_rank(58 * 21 + 1 * 7 + 6);
        send_rank(3 * 21 + 2);
        wait_idle();
        write_reg(CFG_DEST, 63 * 2 * 5);
        send_rank(0);
        wait_idle();

        // Zero counts act as one rank, oversized counts saturate; unused index is ignored.
        set_grids(0, 127, 2, 65, 0, 3, 64 * 3 - 2);
        write_reg(CFG_UNUSED, 2 ** RANK_W - 1);
        send_rank(0);
        send_rank(63 * 2 + 1);
        send_rank(64 * 2);
        send_rank(20);
        wait_idle();

        // Random grids, mostly ranks in range with random content.
        for (int phase = 0; phase < 7; phase++) begin
            no_gaps = (phase == 3);
            set_grids(rand_count(), rand_count(), rand_count(),
                      rand_count(), rand_count(), rand_count(), 0);
            total = rank_total(3);
            if ($urandom_range(0, 9) == 0)
                write_reg(CFG_DEST, $urandom_range(0, 2 ** RANK_W - 1));
            else
                write_reg(CFG_DEST, $urandom_range(0, 32'(total - 1)));
            total = rank_total(0);
            for (int n = 0; n < 21; n++) begin
                if ($urandom_range(0, 9) < 8)
                    send_rank($urandom_range(0, 32'(total - 1)));
                else
                    send_rank($urandom_range(0, 2 ** RANK_W - 1));
            end
            wait_idle();
        end

        if (tracker.errors == 0)
            $display("[block_decomposition_remap_boxes] OK");
        else
            $display("[block_decomposition_remap_boxes] ERROR");
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/brb_pkg.sv
rtl/core/brb_div.sv
rtl/core/brb_span.sv
rtl/core/brb_emit.sv
rtl/core/block_decomposition_remap_boxes.sv
rtl/core/brb_chk.sv
tb/block_decomposition_remap_boxes_tb.sv
